/* hdl/rlgd_pkg.sv */
// rlgd_pkg: shared types and constants of the run-length grid decoder
// used by the channel interfaces, the controller, the datapath and the top level
package rlgd_pkg;

  // default grid limits, handed to the top-level parameters
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int MAX_LINES_DEF   = 1024;

  // cells carried by one result
  localparam int LANES = 4;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int RUN_W    = 9;
  localparam int INDEX_W  = 20;
  localparam int DIM_W    = 11;
  localparam int COUNT_W  = 3;
  localparam int STATUS_W = 3;

  // largest value an 11-bit dimension register can hold
  localparam int DIM_REG_MAX = 2047;

  // marker characters
  localparam logic [BYTE_W-1:0] MARK_ENTRY = 8'h50;
  localparam logic [BYTE_W-1:0] MARK_EXIT  = 8'h4B;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_WORD  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MARKER    = 3'd4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT      = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the input item
    logic calc;     // register the grid size
    logic eval;     // classify the word
    logic drop;     // swallow a word while an error is pending
    logic emit;     // load one result into the output register
  } rlgd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic error_seen;  // sticky error pending
    logic last;        // the next result is the last of this word
  } rlgd_sts_t;

endpackage

/* hdl/rlgd_if.sv */
// rlgd_if: valid/ready channel interfaces for code words and results
// depends on rlgd_pkg for field widths
interface rlgd_in_if;
  logic                          valid;
  logic                          ready;
  logic [rlgd_pkg::BYTE_W-1:0]   word_separator;
  logic [rlgd_pkg::BYTE_W-1:0]   run_char;
  logic [rlgd_pkg::BYTE_W-1:0]   run_extra;
  logic                          final_word;

  modport source (output valid, word_separator, run_char, run_extra, final_word,
                  input ready);
  modport sink (input valid, word_separator, run_char, run_extra, final_word,
                output ready);
endinterface

interface rlgd_out_if;
  logic                           valid;
  logic                           ready;
  logic [rlgd_pkg::INDEX_W-1:0]   first_cell;
  logic [rlgd_pkg::BYTE_W-1:0]    cell_a;
  logic [rlgd_pkg::BYTE_W-1:0]    cell_b;
  logic [rlgd_pkg::BYTE_W-1:0]    cell_c;
  logic [rlgd_pkg::BYTE_W-1:0]    cell_d;
  logic [rlgd_pkg::COUNT_W-1:0]   cells_valid;
  logic                           run_done;
  logic [rlgd_pkg::STATUS_W-1:0]  status;

  modport source (output valid, first_cell, cell_a, cell_b, cell_c, cell_d,
                  cells_valid, run_done, status, input ready);
  modport sink (input valid, first_cell, cell_a, cell_b, cell_c, cell_d,
                cells_valid, run_done, status, output ready);
endinterface

/* hdl/rlgd_ctrl.sv */
// rlgd_ctrl: sequencing of one code word and the output valid flag
// depends on rlgd_pkg for the command and status structs
module rlgd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rlgd_pkg::rlgd_sts_t sts,
  output rlgd_pkg::rlgd_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_EVAL,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_load;

  assign can_load  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.error_seen) begin
          cmd.drop  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.eval  = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          cmd.emit = 1'b1;
          if (sts.last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/rlgd_datapath.sv */
// rlgd_datapath: configuration registers, grid position, word checks and result builder
// depends on rlgd_pkg; driven by rlgd_ctrl through rlgd_cmd_t
module rlgd_datapath #(
  parameter int MAX_COLUMNS = rlgd_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_LINES   = rlgd_pkg::MAX_LINES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rlgd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlgd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [rlgd_pkg::BYTE_W-1:0]       in_word_separator,
  input  logic [rlgd_pkg::BYTE_W-1:0]       in_run_char,
  input  logic [rlgd_pkg::BYTE_W-1:0]       in_run_extra,
  input  logic                              in_final_word,
  input  rlgd_pkg::rlgd_cmd_t               cmd,
  output rlgd_pkg::rlgd_sts_t               sts,
  output logic [rlgd_pkg::INDEX_W-1:0]      out_first_cell,
  output logic [rlgd_pkg::BYTE_W-1:0]       out_cell_a,
  output logic [rlgd_pkg::BYTE_W-1:0]       out_cell_b,
  output logic [rlgd_pkg::BYTE_W-1:0]       out_cell_c,
  output logic [rlgd_pkg::BYTE_W-1:0]       out_cell_d,
  output logic [rlgd_pkg::COUNT_W-1:0]      out_cells_valid,
  output logic                              out_run_done,
  output logic [rlgd_pkg::STATUS_W-1:0]     out_status
);

  localparam int BW = rlgd_pkg::BYTE_W;
  localparam int DW = rlgd_pkg::DIM_W;
  localparam int RW = rlgd_pkg::RUN_W;
  localparam int XW = rlgd_pkg::INDEX_W;
  localparam int CNW = rlgd_pkg::COUNT_W;
  localparam int SW = rlgd_pkg::STATUS_W;
  localparam int NL = rlgd_pkg::LANES;
  localparam int COL_EFF = MAX_COLUMNS < rlgd_pkg::DIM_REG_MAX ? MAX_COLUMNS
                                                               : rlgd_pkg::DIM_REG_MAX;
  localparam int LIN_EFF = MAX_LINES < rlgd_pkg::DIM_REG_MAX ? MAX_LINES
                                                             : rlgd_pkg::DIM_REG_MAX;
  localparam int TOT_W = $clog2(COL_EFF * LIN_EFF + 1);
  localparam int IDX_W = TOT_W > XW ? TOT_W : XW;
  localparam logic [DW-1:0] COL_MAX = DW'(COL_EFF);
  localparam logic [DW-1:0] LIN_MAX = DW'(LIN_EFF);

  // configuration registers
  logic [DW-1:0] cols_r, lines_r;
  logic [BW-1:0] sep_r, wall_r, path_r;
  logic [XW-1:0] entry_r, exit_r;

  // block state
  logic [TOT_W-1:0] pos_r;
  logic             err_r;

  // per-word registers
  logic [BW-1:0]    wsep_r, char_r;
  logic [RW-1:0]    n_r, done_r;
  logic             fin_r, bad_r, under_r;
  logic [SW-1:0]    status_r;
  logic [TOT_W-1:0] total_r;

  // result register
  logic [XW-1:0]  first_r;
  logic [BW-1:0]  cell_r [NL];
  logic [CNW-1:0] valid_cnt_r;
  logic           done_flag_r;
  logic [SW-1:0]  out_status_r;

  logic [DW-1:0]      cols_c, lines_c;
  logic [2*DW-1:0]    prod;
  logic [IDX_W-1:0]   pos_w, total_w, avail_w, n_w, entry_w, exit_w, base_w;
  logic               mark_bad, word_bad, ovf;
  logic [SW-1:0]      status_c;
  logic [RW-1:0]      rem;
  logic [CNW-1:0]     take;
  logic               last_chunk;
  logic [BW-1:0]      lane_chr [NL];

  // grid size, clamped to the supported range
  always_comb begin
    cols_c  = (cols_r == '0) ? DW'(1) : ((cols_r > COL_MAX) ? COL_MAX : cols_r);
    lines_c = (lines_r == '0) ? DW'(1) : ((lines_r > LIN_MAX) ? LIN_MAX : lines_r);
    prod    = cols_c * lines_c;
  end

  // word classification
  always_comb begin
    pos_w   = IDX_W'(pos_r);
    total_w = IDX_W'(total_r);
    n_w     = IDX_W'(n_r);
    entry_w = IDX_W'(entry_r);
    exit_w  = IDX_W'(exit_r);
    avail_w = (pos_w < total_w) ? (total_w - pos_w) : '0;
    mark_bad = (pos_r == '0) && ((entry_w >= total_w) || (exit_w >= total_w));
    word_bad = (wsep_r != sep_r) || ((char_r != path_r) && (char_r != wall_r));
    ovf      = (n_w > avail_w) || ((n_w == avail_w) && !fin_r);
    priority if (mark_bad) status_c = rlgd_pkg::ST_MARKER;
    else if (word_bad)     status_c = rlgd_pkg::ST_BAD_WORD;
    else if (ovf)          status_c = rlgd_pkg::ST_OVERFLOW;
    else                   status_c = rlgd_pkg::ST_OK;
  end

  // one chunk of up to four cells
  always_comb begin
    rem        = n_r - done_r;
    last_chunk = (rem <= RW'(NL));
    take       = last_chunk ? CNW'(rem) : CNW'(NL);
    base_w     = pos_w + IDX_W'(done_r);
    for (int k = 0; k < NL; k++) begin
      if (CNW'(k) >= take) lane_chr[k] = '0;
      else if (base_w + IDX_W'(k) == exit_w) lane_chr[k] = rlgd_pkg::MARK_EXIT;
      else if (base_w + IDX_W'(k) == entry_w) lane_chr[k] = rlgd_pkg::MARK_ENTRY;
      else lane_chr[k] = char_r;
    end
  end

  assign sts.error_seen = err_r;
  assign sts.last       = bad_r || last_chunk;

  // configuration and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= DW'(1);
      lines_r <= DW'(1);
      sep_r   <= 8'd0;
      wall_r  <= 8'd88;
      path_r  <= 8'd32;
      entry_r <= '0;
      exit_r  <= '0;
      pos_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rlgd_pkg::CFG_COLUMNS:   cols_r  <= cfg_data[DW-1:0];
          rlgd_pkg::CFG_LINES:     lines_r <= cfg_data[DW-1:0];
          rlgd_pkg::CFG_SEPARATOR: sep_r   <= cfg_data[BW-1:0];
          rlgd_pkg::CFG_WALL:      wall_r  <= cfg_data[BW-1:0];
          rlgd_pkg::CFG_PATH:      path_r  <= cfg_data[BW-1:0];
          rlgd_pkg::CFG_ENTRY:     entry_r <= cfg_data[XW-1:0];
          rlgd_pkg::CFG_EXIT:      exit_r  <= cfg_data[XW-1:0];
          default: ;
        endcase
      end
      if (cmd.drop && fin_r) begin
        err_r <= 1'b0;
        pos_r <= '0;
      end
      if (cmd.emit) begin
        if (bad_r) begin
          err_r <= !fin_r;
          if (fin_r) pos_r <= '0;
        end else if (last_chunk) begin
          pos_r <= fin_r ? '0 : TOT_W'(pos_w + n_w);
        end
      end
    end
  end

  // word registers and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      wsep_r <= in_word_separator;
      char_r <= in_run_char;
      n_r    <= RW'(in_run_extra) + RW'(1);
      fin_r  <= in_final_word;
    end
    if (cmd.calc) total_r <= prod[TOT_W-1:0];
    if (cmd.eval) begin
      status_r <= status_c;
      bad_r    <= (status_c != rlgd_pkg::ST_OK);
      under_r  <= fin_r && (n_w < avail_w);
      done_r   <= '0;
    end
    if (cmd.emit) begin
      if (bad_r) begin
        first_r      <= pos_w[XW-1:0];
        for (int k = 0; k < NL; k++) cell_r[k] <= '0;
        valid_cnt_r  <= '0;
        done_flag_r  <= 1'b1;
        out_status_r <= status_r;
      end else begin
        first_r      <= base_w[XW-1:0];
        for (int k = 0; k < NL; k++) cell_r[k] <= lane_chr[k];
        valid_cnt_r  <= take;
        done_flag_r  <= last_chunk;
        out_status_r <= (last_chunk && under_r) ? rlgd_pkg::ST_UNDERFLOW : rlgd_pkg::ST_OK;
        done_r       <= done_r + RW'(take);
      end
    end
  end

  assign out_first_cell  = first_r;
  assign out_cell_a      = cell_r[0];
  assign out_cell_b      = cell_r[1];
  assign out_cell_c      = cell_r[2];
  assign out_cell_d      = cell_r[3];
  assign out_cells_valid = valid_cnt_r;
  assign out_run_done    = done_flag_r;
  assign out_status      = out_status_r;

endmodule

/* hdl/run_length_grid_decoder.sv */
// run_length_grid_decoder: top level of the run-length grid decoder
// instantiates rlgd_ctrl and rlgd_datapath; uses rlgd_pkg and the rlgd_if channels
//
// in_ch takes one three-byte code word per item (separator, character, run length
// minus one, last-word flag). out_ch returns results of up to four grid cells each,
// with the linear index of the first cell, a count of valid cells, a flag on the
// last result of the word and a status code.
// cfg_we/cfg_index/cfg_data write the grid size, byte codes and marker indices;
// write them only while no word is in flight.
// Timing: the controller takes a word in S_IDLE, forms the grid size in S_CALC
// (one 11x11 multiply), checks the word in S_EVAL, and in S_EMIT loads one result
// per cycle into the output register while that register is free. A rejected word
// gives a single result with no cells; a word dropped after an error gives none.
// The next word is taken once the last result of the current one sits in the
// output register.
// When the receiver stalls, the result waits in the output register and the
// result builder stops; nothing is lost.
// Reset loads the register defaults (1 by 1 grid, separator 0, wall 88, path 32,
// markers at 0), clears the grid position and any pending error.
module run_length_grid_decoder #(
  parameter int MAX_COLUMNS = rlgd_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_LINES   = rlgd_pkg::MAX_LINES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rlgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlgd_pkg::CFG_DATA_W-1:0] cfg_data,
  rlgd_in_if.sink                         in_ch,
  rlgd_out_if.source                      out_ch
);

  rlgd_pkg::rlgd_cmd_t cmd;
  rlgd_pkg::rlgd_sts_t sts;

  rlgd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rlgd_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_LINES   (MAX_LINES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_word_separator (in_ch.word_separator),
    .in_run_char       (in_ch.run_char),
    .in_run_extra      (in_ch.run_extra),
    .in_final_word     (in_ch.final_word),
    .cmd               (cmd),
    .sts               (sts),
    .out_first_cell    (out_ch.first_cell),
    .out_cell_a        (out_ch.cell_a),
    .out_cell_b        (out_ch.cell_b),
    .out_cell_c        (out_ch.cell_c),
    .out_cell_d        (out_ch.cell_d),
    .out_cells_valid   (out_ch.cells_valid),
    .out_run_done      (out_ch.run_done),
    .out_status        (out_ch.status)
  );

  // one word at a time: no new item right after one is taken
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken twice in a row");

  // a result never carries more than four cells
  a_cell_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.cells_valid <= 3'd4)
    else $error("cell count out of range");

  // any non-ok status is only on the last result of a word
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != rlgd_pkg::ST_OK |-> out_ch.run_done)
    else $error("status on a non-final result");

  // a rejected word carries no cells
  a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == rlgd_pkg::ST_BAD_WORD ||
                     out_ch.status == rlgd_pkg::ST_OVERFLOW ||
                     out_ch.status == rlgd_pkg::ST_MARKER)
    |-> out_ch.cells_valid == 3'd0)
    else $error("rejected word carries cells");

  // the builder only loads a result when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_ch.valid || out_ch.ready)
    else $error("result overwritten before it was taken");

endmodule
